### src/lru_key_value_cache_defines.svh
// Assertion macros for the LRU key-value cache.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LKV_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lkv: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define LKV_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lkv: next-cycle check failed");

`endif

### src/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by lkv_store, lkv_recency and lru_key_value_cache.
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int EC_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic signed [KEY_W-1:0] lookup_key;
      logic signed [VAL_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] read_value;
      logic                    evicted;
      logic signed [KEY_W-1:0] evicted_key;
   } rsp_type;

   // Recency update command: promote slot, optionally making it valid
   typedef struct packed {
      logic             en;
      logic             insert;
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] thr;
   } rank_cmd_type;

   // Key/value store write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } store_wr_type;

endpackage

### src/lkv_store.sv
// Key and value memories of the cache: one write port, one registered read port.
// Depends on lkv_pkg.
module lkv_store (
   input  logic                      clock,
   input  lkv_pkg::store_wr_type     wr,
   input  logic [lkv_pkg::IDX_W-1:0] rd_addr,
   output logic [lkv_pkg::KEY_W-1:0] rd_key_ff,
   output logic [lkv_pkg::VAL_W-1:0] rd_value_ff
);

   logic [lkv_pkg::KEY_W-1:0] key_mem [lkv_pkg::ENTRIES];
   logic [lkv_pkg::VAL_W-1:0] val_mem [lkv_pkg::ENTRIES];

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.key;
         val_mem[wr.addr] <= wr.value;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= val_mem[rd_addr];
   end

endmodule

### src/lkv_recency.sv
// Per-entry valid bits and recency ranks (0 = most recent) of the cache.
// Depends on lkv_pkg.
module lkv_recency (
   input  logic                       clock,
   input  logic                       reset,
   input  lkv_pkg::rank_cmd_type      cmd,
   input  logic [lkv_pkg::IDX_W-1:0]  rd_idx,
   output logic                       rd_valid,
   output logic [lkv_pkg::RANK_W-1:0] rd_rank
);

   logic [lkv_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [lkv_pkg::RANK_W-1:0]  rank_ff [lkv_pkg::ENTRIES];
   logic [lkv_pkg::RANK_W-1:0]  rank_in [lkv_pkg::ENTRIES];

   // Promote: target goes to rank 0, valid entries more recent than it age by one
   always_comb begin
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (cmd.en) begin
            if (cmd.slot == lkv_pkg::IDX_W'(i)) begin
               rank_in[i] = '0;
               if (cmd.insert) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (lkv_pkg::CNT_W'(rank_ff[i]) < cmd.thr)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Read port for the scan
   assign rd_valid = valid_ff[rd_idx];
   assign rd_rank  = rank_ff[rd_idx];

endmodule

### src/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement. One
// transaction (get or put) is handled at a time: after acceptance a single key
// comparator walks the ENTRIES slots, one per cycle through the store's one read
// port, then a drain state empties the read pipeline and an update state writes
// the store, the recency ranks and the response register. The update waits until
// the previous response has been taken, and a new transaction is accepted only
// back in idle. The capacity register (reset 16, 0 acts as 1, values above the
// entry count act as the entry count) may only be written while the cache is
// idle. All entries are invalid after reset.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lkv_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lkv_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [lkv_pkg::CAP_W-1:0]     csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   state_type                  state_ff, state_in;
   lkv_pkg::req_type           req_ff, req_in;
   lkv_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lkv_pkg::CAP_W-1:0]  cap_ff, cap_in;

   logic [lkv_pkg::IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [lkv_pkg::IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                       cmp_live_ff, cmp_live_in;

   logic                       found_ff, found_in;
   logic [lkv_pkg::IDX_W-1:0]  hit_ff, hit_in;
   logic [lkv_pkg::RANK_W-1:0] hit_rank_ff, hit_rank_in;
   logic [lkv_pkg::VAL_W-1:0]  hit_val_ff, hit_val_in;
   logic [lkv_pkg::IDX_W-1:0]  lru_ff, lru_in;
   logic [lkv_pkg::RANK_W-1:0] max_rank_ff, max_rank_in;
   logic [lkv_pkg::KEY_W-1:0]  lru_key_ff, lru_key_in;
   logic [lkv_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       have_free_ff, have_free_in;
   logic [lkv_pkg::IDX_W-1:0]  free_ff, free_in;

   logic [lkv_pkg::KEY_W-1:0]  rd_key;
   logic [lkv_pkg::VAL_W-1:0]  rd_value;
   logic                       rd_valid;
   logic [lkv_pkg::RANK_W-1:0] rd_rank;
   logic [lkv_pkg::IDX_W-1:0]  rd_addr;

   lkv_pkg::store_wr_type      store_wr;
   lkv_pkg::rank_cmd_type      rank_cmd;

   logic [lkv_pkg::EC_W-1:0]   eff_cap;
   logic                       is_put;
   logic                       do_evict;
   logic                       out_free;

   lkv_store u_store (
      .clock       (clock),
      .wr          (store_wr),
      .rd_addr     (rd_addr),
      .rd_key_ff   (rd_key),
      .rd_value_ff (rd_value)
   );

   lkv_recency u_recency (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rank_cmd),
      .rd_idx   (cmp_idx_ff),
      .rd_valid (rd_valid),
      .rd_rank  (rd_rank)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rd_addr     = scan_idx_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Effective capacity, clamped to 1..ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lkv_pkg::EC_W'(1);
      end else if (lkv_pkg::EC_W'(cap_ff) > lkv_pkg::EC_W'(lkv_pkg::ENTRIES)) begin
         eff_cap = lkv_pkg::EC_W'(lkv_pkg::ENTRIES);
      end else begin
         eff_cap = lkv_pkg::EC_W'(cap_ff);
      end
   end

   assign is_put   = (req_ff.opcode == lkv_pkg::OP_PUT);
   assign do_evict = is_put && !found_ff &&
                     ((lkv_pkg::EC_W'(count_ff) >= eff_cap) || !have_free_ff);

   // Sequencer, compare unit and update
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cap_in       = csr_write_enable ? csr_write_data : cap_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_idx_in   = scan_idx_ff;
      cmp_live_in  = (state_ff == ST_SCAN);
      found_in     = found_ff;
      hit_in       = hit_ff;
      hit_rank_in  = hit_rank_ff;
      hit_val_in   = hit_val_ff;
      lru_in       = lru_ff;
      max_rank_in  = max_rank_ff;
      lru_key_in   = lru_key_ff;
      count_in     = count_ff;
      have_free_in = have_free_ff;
      free_in      = free_ff;
      store_wr     = '0;
      rank_cmd     = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Compare one slot per cycle, in the cycle after its read was issued
      if (cmp_live_ff) begin
         if (rd_valid) begin
            count_in = count_ff + 1'b1;
            if (!found_ff && (rd_key == req_ff.lookup_key)) begin
               found_in    = 1'b1;
               hit_in      = cmp_idx_ff;
               hit_rank_in = rd_rank;
               hit_val_in  = rd_value;
            end
            if (rd_rank >= max_rank_ff) begin
               max_rank_in = rd_rank;
               lru_in      = cmp_idx_ff;
               lru_key_in  = rd_key;
            end
         end else if (!have_free_ff) begin
            have_free_in = 1'b1;
            free_in      = cmp_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_payload;
               scan_idx_in  = '0;
               found_in     = 1'b0;
               hit_in       = '0;
               hit_rank_in  = '0;
               lru_in       = '0;
               max_rank_in  = '0;
               count_in     = '0;
               have_free_in = 1'b0;
               free_in      = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == lkv_pkg::IDX_W'(lkv_pkg::ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = found_ff;
               rsp_in.evicted     = do_evict;
               rsp_in.evicted_key = do_evict ? lru_key_ff : '0;
               state_in           = ST_IDLE;
               if (!is_put) begin
                  // Get: hit promotes, miss changes nothing
                  rsp_in.read_value = found_ff ? hit_val_ff : lkv_pkg::MISS_VALUE;
                  rank_cmd.en       = found_ff;
                  rank_cmd.slot     = hit_ff;
                  rank_cmd.thr      = lkv_pkg::CNT_W'(hit_rank_ff);
               end else begin
                  rsp_in.read_value = req_ff.store_value;
                  store_wr.en       = 1'b1;
                  store_wr.key      = req_ff.lookup_key;
                  store_wr.value    = req_ff.store_value;
                  rank_cmd.en       = 1'b1;
                  if (found_ff) begin
                     store_wr.addr = hit_ff;
                     rank_cmd.slot = hit_ff;
                     rank_cmd.thr  = lkv_pkg::CNT_W'(hit_rank_ff);
                  end else if (do_evict) begin
                     store_wr.addr = lru_ff;
                     rank_cmd.slot = lru_ff;
                     rank_cmd.thr  = lkv_pkg::CNT_W'(max_rank_ff);
                  end else begin
                     store_wr.addr   = free_ff;
                     rank_cmd.slot   = free_ff;
                     rank_cmd.insert = 1'b1;
                     rank_cmd.thr    = count_ff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control and payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      hit_rank_ff  <= hit_rank_in;
      hit_val_ff   <= hit_val_in;
      lru_ff       <= lru_in;
      max_rank_ff  <= max_rank_in;
      lru_key_ff   <= lru_key_in;
      count_ff     <= count_in;
      have_free_ff <= have_free_in;
      free_ff      <= free_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_live_ff  <= 1'b0;
         cap_ff       <= lkv_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_live_ff  <= cmp_live_in;
         cap_ff       <= cap_in;
      end
   end

   // A hit never evicts
   `LKV_ASSERT_IMP(a_hit_no_evict, rsp_valid_ff, !(rsp_ff.found && rsp_ff.evicted))
   // Evicted key is zero unless an eviction is reported
   `LKV_ASSERT_IMP(a_evkey_zero, rsp_valid_ff && !rsp_ff.evicted, rsp_ff.evicted_key == '0)
   // An accepted transaction starts the slot scan at the first entry
   `LKV_ASSERT_NXT(a_scan_start, req_valid && req_ready,
                   (state_ff == ST_SCAN) && (scan_idx_ff == '0))

endmodule
